### rtl/core/pkc_pkg.sv
// pkc_pkg: shared constants and types for the packet keystream cipher
`timescale 1ns / 1ps

package pkc_pkg;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned GEN_W   = 32;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned KIND_W  = 8;
    localparam int unsigned POS_W   = 6;
    localparam int unsigned LANE_W  = 2;

    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [GEN_W-1:0]  gen_t;
    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [KIND_W-1:0] kind_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LANE_W-1:0] lane_t;

    localparam gen_t  LCG_MULT     = 32'h0808_8405;
    localparam gen_t  LCG_SEED     = 32'h04A8_0B38;
    localparam kind_t LONG_KIND    = 8'h02;
    localparam int unsigned LONG_GROUPS  = 12;
    localparam int unsigned SHORT_GROUPS = 4;
    localparam int unsigned GROUP_BYTES  = 4;

    localparam pos_t LONG_LIMIT  = POS_W'(LONG_GROUPS * GROUP_BYTES);
    localparam pos_t SHORT_LIMIT = POS_W'(SHORT_GROUPS * GROUP_BYTES);
    // position stops here, at the largest limit
    localparam pos_t POS_CAP     = POS_W'(LONG_GROUPS * GROUP_BYTES);

    localparam lane_t LANE_0 = 2'd0;
    localparam lane_t LANE_1 = 2'd1;
    localparam lane_t LANE_2 = 2'd2;
    localparam lane_t LANE_3 = 2'd3;

endpackage

### rtl/core/pkc_if.sv
// pkc_if: valid/ready channel interfaces for the cipher's input, output and key port
`timescale 1ns / 1ps

interface pkc_in_if;
    logic             valid;
    logic             ready;
    logic             mode;
    logic             start_of_packet;
    pkc_pkg::kind_t   packet_kind;
    pkc_pkg::byte_t   data_in;

    modport source (output valid, output mode, output start_of_packet,
                    output packet_kind, output data_in, input ready);
    modport sink   (input valid, input mode, input start_of_packet,
                    input packet_kind, input data_in, output ready);
endinterface

interface pkc_out_if;
    logic             valid;
    logic             ready;
    pkc_pkg::byte_t   data_out;

    modport source (output valid, output data_out, input ready);
    modport sink   (input valid, input data_out, output ready);
endinterface

interface pkc_cfg_if;
    logic             valid;
    logic             ready;
    pkc_pkg::key_t    cipher_key;

    modport source (output valid, output cipher_key, input ready);
    modport sink   (input valid, input cipher_key, output ready);
endinterface

### rtl/core/packet_keystream_cipher_top.sv
// packet_keystream_cipher_top: byte-wide keystream xor cipher with send/receive generators
`timescale 1ns / 1ps

// Packet keystream cipher. One packet byte per beat enters on in_ch together with
// its direction mode, a start-of-packet flag and the packet's compression type; one
// ciphered byte per beat leaves on out_ch. Two 32-bit generators (send for mode 0,
// receive for mode 1) persist across packets and reset to 0x4A80B38. At byte
// positions 0, 4, 8, ... of a packet the selected generator steps as
// g = g * 0x8088405 + key (mod 2^32) and the byte is xored with lane (position mod 4)
// of it, lane 0 least significant. Coverage ends after 48 bytes when the type is 2
// and after 16 bytes otherwise; later bytes and every byte under a zero key pass
// through. The type is only looked at on a start-of-packet beat; bytes before the
// first start mark count as a short packet begun at reset.
// Throughput: one byte per clock while out_ch is not stalled. A byte accepted on in_ch
// is held in the input register, processed into the result register and offered on
// out_ch from there. The path that sets the clock is the generator step, one 32x32
// constant multiply plus the key add and a lane mux, between the input register and
// the result register.
// The key is loaded over cfg_ch (always ready) and must be written only while no
// byte is in flight.

module packet_keystream_cipher_top (
    input  logic      clk,
    input  logic      rst_n,
    pkc_in_if.sink    in_ch,
    pkc_out_if.source out_ch,
    pkc_cfg_if.sink   cfg_ch
);

    // input register
    logic             in_valid_reg;
    logic             mode_reg;
    logic             sop_reg;
    pkc_pkg::kind_t   kind_reg;
    pkc_pkg::byte_t   data_reg;

    // result register
    logic             out_valid_reg;
    pkc_pkg::byte_t   out_data_reg;
    pkc_pkg::byte_t   out_data_next;

    // cipher state
    pkc_pkg::key_t    key_reg;
    pkc_pkg::gen_t    send_gen_reg;
    pkc_pkg::gen_t    send_gen_next;
    pkc_pkg::gen_t    recv_gen_reg;
    pkc_pkg::gen_t    recv_gen_next;
    pkc_pkg::pos_t    pos_reg;
    pkc_pkg::pos_t    pos_next;
    logic             long_reg;
    logic             long_next;

    // datapath
    logic             advance;
    logic             process;
    pkc_pkg::pos_t    pos_eff;
    pkc_pkg::pos_t    limit;
    logic             covered;
    logic             gen_step;
    pkc_pkg::gen_t    gen_cur;
    pkc_pkg::gen_t    gen_stepped;
    pkc_pkg::gen_t    gen_used;
    pkc_pkg::byte_t   lane_byte;

    // result register frees up when empty or when its beat is taken
    assign advance      = !out_valid_reg || out_ch.ready;
    assign process      = in_valid_reg && advance;
    // input register takes a new beat whenever its current one moves on
    assign in_ch.ready  = !in_valid_reg || advance;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data_out = out_data_reg;
    assign cfg_ch.ready = 1'b1;

    // a start mark restarts the position and samples the packet type
    assign pos_eff   = sop_reg ? '0 : pos_reg;
    assign long_next = sop_reg ? (kind_reg == pkc_pkg::LONG_KIND) : long_reg;
    assign limit     = long_next ? pkc_pkg::LONG_LIMIT : pkc_pkg::SHORT_LIMIT;
    assign covered   = (key_reg != '0) && (pos_eff < limit);
    assign gen_step  = covered && (pos_eff[pkc_pkg::LANE_W-1:0] == pkc_pkg::LANE_0);

    // generator step: the one multiply of the design
    assign gen_cur     = mode_reg ? recv_gen_reg : send_gen_reg;
    assign gen_stepped = gen_cur * pkc_pkg::LCG_MULT + key_reg;
    assign gen_used    = gen_step ? gen_stepped : gen_cur;

    always_comb
    begin
        case (pos_eff[pkc_pkg::LANE_W-1:0])
            pkc_pkg::LANE_0: lane_byte = gen_used[7:0];
            pkc_pkg::LANE_1: lane_byte = gen_used[15:8];
            pkc_pkg::LANE_2: lane_byte = gen_used[23:16];
            default:         lane_byte = gen_used[31:24];
        endcase
    end

    assign out_data_next = covered ? (data_reg ^ lane_byte) : data_reg;

    // only the selected generator moves
    assign send_gen_next = (!mode_reg && gen_step) ? gen_stepped : send_gen_reg;
    assign recv_gen_next = ( mode_reg && gen_step) ? gen_stepped : recv_gen_reg;

    // position saturates so long packets never wrap back into coverage
    assign pos_next = (pos_eff < pkc_pkg::POS_CAP) ? pos_eff + 1'b1 : pos_eff;

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= '0;
            send_gen_reg  <= pkc_pkg::LCG_SEED;
            recv_gen_reg  <= pkc_pkg::LCG_SEED;
            pos_reg       <= '0;
            long_reg      <= 1'b0;
        end
        else
        begin
            if (in_ch.ready)
            begin
                in_valid_reg <= in_ch.valid;
            end
            if (advance)
            begin
                out_valid_reg <= in_valid_reg;
            end
            if (cfg_ch.valid)
            begin
                key_reg <= cfg_ch.cipher_key;
            end
            if (process)
            begin
                send_gen_reg <= send_gen_next;
                recv_gen_reg <= recv_gen_next;
                pos_reg      <= pos_next;
                long_reg     <= long_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            mode_reg <= in_ch.mode;
            sop_reg  <= in_ch.start_of_packet;
            kind_reg <= in_ch.packet_kind;
            data_reg <= in_ch.data_in;
        end
        if (process)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // position never runs past its cap
    a_pos_capped: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= pkc_pkg::POS_CAP)
        else $error("byte position past cap");

    // a zero key leaves both generators untouched
    a_zero_key_holds: assert property (@(posedge clk) disable iff (!rst_n)
        process && (key_reg == '0) |=> $stable(send_gen_reg) && $stable(recv_gen_reg))
        else $error("generator stepped under zero key");

    // a send-direction byte never disturbs the receive generator
    a_send_keeps_recv: assert property (@(posedge clk) disable iff (!rst_n)
        process && !mode_reg |=> $stable(recv_gen_reg))
        else $error("receive generator moved on a send byte");

    // a result only appears from a byte held in the input register
    a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result beat without a source byte");

    // input stalls only when both registers are full and the output is stalled
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> in_valid_reg && out_valid_reg && !out_ch.ready)
        else $error("input stalled without a full pipeline");

endmodule

### tb/tb.sv
// tb: self-checking testbench for the packet keystream cipher with scoreboard and traffic tasks
`timescale 1ns / 1ps

module tb;

    import pkc_pkg::*;

    // direction select carried on every beat
    localparam logic MODE_SEND = 1'b0;
    localparam logic MODE_RECV = 1'b1;

    // receiver ready styles, switched at random by the ready driver
    typedef enum int unsigned {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_BURSTY
    } rx_style_e;

    // keystream predictor plus the queue of bytes still owed by the block
    class keystream_scoreboard;
        gen_t        send_gen;
        gen_t        recv_gen;
        pos_t        byte_pos;
        bit          long_pkt;
        key_t        key;
        byte_t       owed_bytes[$];
        int unsigned errors;
        int unsigned beats_in;
        int unsigned beats_out;
        int unsigned packets;
        int unsigned ciphered;

        function new();
            send_gen  = LCG_SEED;
            recv_gen  = LCG_SEED;
            byte_pos  = '0;
            long_pkt  = 1'b0;
            key       = '0;
            errors    = 0;
            beats_in  = 0;
            beats_out = 0;
            packets   = 0;
            ciphered  = 0;
        endfunction

        function void set_key(key_t k);
            key = k;
        endfunction

        function int unsigned pending();
            return owed_bytes.size();
        endfunction

        // works out the byte the block must return for one accepted input beat
        function void note_beat(logic mode, logic sop, kind_t kind, byte_t data);
            pos_t  pos;
            pos_t  limit;
            gen_t  g;
            byte_t res;
            lane_t lane;
            if (sop)
            begin
                byte_pos = '0;
                long_pkt = (kind == LONG_KIND);
                packets++;
            end
            pos   = byte_pos;
            limit = long_pkt ? LONG_LIMIT : SHORT_LIMIT;
            g     = (mode == MODE_RECV) ? recv_gen : send_gen;
            res   = data;
            if (key != '0 && pos < limit)
            begin
                lane = pos[LANE_W-1:0];
                if (lane == LANE_0)
                    g = g * LCG_MULT + key;
                res = data ^ byte_t'(g >> (8 * lane));
                ciphered++;
            end
            if (mode == MODE_RECV)
                recv_gen = g;
            else
                send_gen = g;
            if (byte_pos < POS_CAP)
                byte_pos = byte_pos + 1'b1;
            owed_bytes = {owed_bytes, res};
            beats_in++;
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(byte_t got);
            byte_t want;
            beats_out++;
            if (owed_bytes.size() == 0)
            begin
                report_mismatch($sformatf("data_out %02h with no byte pending", got));
            end
            else
            begin
                want = owed_bytes.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("data_out %02h, expected %02h (result beat %0d)",
                                              got, want, beats_out));
            end
        endtask

        task finish_check();
            if (owed_bytes.size() != 0)
                report_mismatch($sformatf("%0d bytes never came out", owed_bytes.size()));
        endtask
    endclass

    logic clk;
    logic rst_n;

    pkc_in_if  in_ch();
    pkc_out_if out_ch();
    pkc_cfg_if cfg_ch();

    keystream_scoreboard sb;

    // cycles the receiver must still hold ready low, set from the main flow
    int unsigned rx_hold_left = 0;
    int unsigned keys_written = 0;

    packet_keystream_cipher_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg_ch (cfg_ch)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // hard stop well past the slowest legal run
    initial
    begin
        #5_000_000;
        $display("timeout: pending %0d", sb.pending());
        $display("Some tests failed");
        $finish;
    end

    // watch both channels at each edge; inputs are noted before outputs are checked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (rst_n)
            begin
                if (in_ch.valid && in_ch.ready)
                    sb.note_beat(in_ch.mode, in_ch.start_of_packet,
                                 in_ch.packet_kind, in_ch.data_in);
                if (out_ch.valid && out_ch.ready)
                    sb.check_result(out_ch.data_out);
            end
        end
    end

    // output ready: rotating styles plus the long hold-off requested by the main flow
    initial
    begin
        rx_style_e   style;
        int unsigned style_left;
        int unsigned stall_run;
        int unsigned rx_cycle;
        out_ch.ready <= 1'b0;
        style      = RX_ALWAYS;
        style_left = 64;
        stall_run  = 0;
        rx_cycle   = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (style_left == 0)
            begin
                style      = rx_style_e'($urandom_range(0, 3));
                style_left = $urandom_range(32, 256);
            end
            style_left--;
            if (rx_hold_left > 0)
            begin
                rx_hold_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                case (style)
                    RX_ALWAYS:   out_ch.ready <= 1'b1;
                    RX_RANDOM:   out_ch.ready <= ($urandom_range(0, 3) != 0);
                    RX_PERIODIC: out_ch.ready <= (rx_cycle % 3 != 0);
                    default:
                    begin
                        if (stall_run > 0)
                        begin
                            stall_run--;
                            out_ch.ready <= 1'b0;
                        end
                        else
                        begin
                            if ($urandom_range(0, 9) == 0)
                                stall_run = $urandom_range(2, 12);
                            out_ch.ready <= 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    // offer one byte beat and hold it until the block takes it
    task automatic send_byte(logic mode, logic sop, kind_t kind, byte_t data);
        in_ch.valid           <= 1'b1;
        in_ch.mode            <= mode;
        in_ch.start_of_packet <= sop;
        in_ch.packet_kind     <= kind;
        in_ch.data_in         <= data;
        do
            @(posedge clk);
        while (!in_ch.ready);
    endtask

    // gap on the input side, lasting the given number of clocks
    task automatic pause_input(int unsigned cycles);
        in_ch.valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // stop offering and wait until every owed byte has come back
    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        // let the monitor note the last accepted beat first
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        // every owed byte is out, leave some margin
        repeat (4) @(posedge clk);
    endtask

    task automatic write_key(key_t k);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.cipher_key <= k;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.set_key(k);
        keys_written++;
        cfg_ch.valid <= 1'b0;
    endtask

    // random packets in bursts; mostly proper packets, some headless runs and mode flips
    task automatic send_packets(int unsigned n_items, bit long_hold);
        int unsigned sent;
        int unsigned len;
        int unsigned burst_left;
        int unsigned gap;
        logic        mode;
        logic        sop_first;
        kind_t       kind;
        sent       = 0;
        burst_left = 0;
        while (sent < n_items)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: len = $urandom_range(1, 8);
                4, 5, 6:    len = $urandom_range(9, 20);
                7, 8:       len = $urandom_range(40, 56);
                default:    len = $urandom_range(57, 70);
            endcase
            kind      = ($urandom_range(0, 1) != 0) ? LONG_KIND : kind_t'($urandom);
            mode      = 1'($urandom_range(0, 1));
            sop_first = ($urandom_range(0, 19) != 0);
            for (int unsigned i = 0; i < len; i++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap        = $urandom_range(0, 6);
                    if (gap != 0)
                        pause_input(gap);
                end
                burst_left--;
                if ($urandom_range(0, 29) == 0)
                    mode = ~mode;
                // type byte is noise except on the start beat
                send_byte(mode, (i == 0) && sop_first,
                          (i == 0) ? kind : kind_t'($urandom), byte_t'($urandom));
                sent++;
                // receiver goes quiet while we keep pushing, so the input backs up
                if (long_hold && sent == n_items / 2)
                    rx_hold_left = 300;
            end
        end
    endtask

    task automatic run_phase(key_t k, int unsigned n_items, bit long_hold);
        wait_for_drain();
        write_key(k);
        send_packets(n_items, long_hold);
    endtask

    initial
    begin
        sb = new();
        rst_n                 <= 1'b0;
        in_ch.valid           <= 1'b0;
        in_ch.mode            <= MODE_SEND;
        in_ch.start_of_packet <= 1'b0;
        in_ch.packet_kind     <= '0;
        in_ch.data_in         <= '0;
        cfg_ch.valid          <= 1'b0;
        cfg_ch.cipher_key     <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // key is zero out of reset: bytes pass straight through
        send_byte(MODE_SEND, 1'b1, LONG_KIND, 8'h00);
        send_byte(MODE_RECV, 1'b0, 8'hFF, 8'hFF);
        wait_for_drain();
        write_key('1);

        // bytes with no start mark of their own: they continue the long packet opened after reset;
        // the third byte steps the untouched receive generator at a group start
        send_byte(MODE_SEND, 1'b0, 8'h00, 8'hA5);
        send_byte(MODE_SEND, 1'b0, LONG_KIND, 8'h5A);
        send_byte(MODE_RECV, 1'b0, 8'h7F, 8'hFF);

        // long packet opened on the receive side, then the send side takes over
        send_byte(MODE_RECV, 1'b1, LONG_KIND, 8'h00);
        send_byte(MODE_SEND, 1'b0, 8'h80, 8'h3C);
        send_byte(MODE_SEND, 1'b0, 8'h01, 8'hC3);

        // short packet run one byte past its limit
        for (int unsigned i = 0; i < 17; i++)
            send_byte(MODE_SEND, i == 0, (i == 0) ? 8'hFF : kind_t'(i),
                      byte_t'(i * 8'h1F));

        run_phase(32'h0000_0001, 250, 1'b0);
        run_phase(32'h0000_0000, 200, 1'b0);
        run_phase(key_t'($urandom), 250, 1'b1);
        run_phase(32'h8000_0000, 200, 1'b0);
        run_phase(key_t'($urandom), 250, 1'b0);
        run_phase(32'hFFFF_FFFF, 250, 1'b0);
        run_phase(key_t'($urandom), 150, 1'b0);

        wait_for_drain();
        repeat (8) @(posedge clk);
        sb.finish_check();

        $display("run covered %0d byte beats in %0d packet starts over %0d key settings",
                 sb.beats_in, sb.packets, keys_written + 1);
        $display("%0d bytes went through the keystream, %0d passed unchanged",
                 sb.ciphered, sb.beats_in - sb.ciphered);
        if (sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
